>>> src/i2c_rbm_pkg.sv
// Shared types and constants for the I2C register burst master.
// Used by the top level, front end, item queue and bus engine.
package i2c_rbm_pkg;

  localparam int TICKS_PER_DELAY_DEF = 1;
  localparam logic [7:0] ACK_WAIT_RESET = 8'd250;
  localparam int QUEUE_DEPTH = 2;

  // func field codes on the command channel
  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_DATA  = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  // classified item kind, as queued for the bus engine
  typedef enum logic [3:0] {
    KIND_NOP   = 4'b0001,
    KIND_START = 4'b0010,
    KIND_DATA  = 4'b0100,
    KIND_TICK  = 4'b1000
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic        is_read;
    logic [6:0]  dev_addr;
    logic [7:0]  reg_addr;
    logic [7:0]  byte_count;
    logic [7:0]  write_data;
    logic        sda_in;
  } item_t;

endpackage

>>> src/i2c_rbm_ifs.sv
// Valid/ready channel interfaces: command items in, bus result items out.
// Depends on nothing but plain logic types.
interface i2c_rbm_cmd_if ();
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic       is_read;
  logic [6:0] dev_addr;
  logic [7:0] reg_addr;
  logic [7:0] byte_count;
  logic [7:0] write_data;
  logic       sda_in;

  modport source (output valid, func, is_read, dev_addr, reg_addr, byte_count,
                  write_data, sda_in, input ready);
  modport sink (input valid, func, is_read, dev_addr, reg_addr, byte_count,
                write_data, sda_in, output ready);
endinterface

interface i2c_rbm_res_if ();
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_drive;
  logic       busy_res;
  logic       need_data;
  logic [7:0] read_data;
  logic       read_valid;
  logic       read_last;
  logic       done_res;
  logic       status;
  logic       cmd_rejected;

  modport source (output valid, scl_level, sda_level, sda_drive, busy_res,
                  need_data, read_data, read_valid, read_last, done_res, status,
                  cmd_rejected, input ready);
  modport sink (input valid, scl_level, sda_level, sda_drive, busy_res,
                need_data, read_data, read_valid, read_last, done_res, status,
                cmd_rejected, output ready);
endinterface

>>> src/i2c_register_burst_master.sv
// Top level of the I2C register burst master: front end, item queue, bus engine.
// Depends on i2c_rbm_pkg, the channel interfaces and the three sub-blocks.
//
//  channel | dir | handshake        | carries
//  cmd     | in  | valid/ready      | func, is_read, dev_addr, reg_addr, byte_count,
//          |     |                  | write_data, sda_in
//  res     | out | valid/ready      | bus levels, busy, need_data, read byte, done, status
//  cfg     | in  | cfg_wr_en only   | ack_wait_limit (reset 250)
//
// One item per clock while res.ready holds; results are registered.
// The bus engine runs one item per cycle unless its one result register stalls.
// A stalled result fills the two-entry queue, after which cmd.ready drops.
// Reset is synchronous; no clearing pass, the block takes items right after reset.
module i2c_register_burst_master import i2c_rbm_pkg::*; #(
  parameter int TICKS_PER_DELAY = TICKS_PER_DELAY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  i2c_rbm_cmd_if.sink   cmd,
  i2c_rbm_res_if.source res
);

  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  i2c_rbm_front u_front (
    .cmd        (cmd),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  i2c_rbm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  i2c_rbm_engine #(
    .TICKS_PER_DELAY (TICKS_PER_DELAY)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pop_valid   (pop_valid),
    .pop_item    (pop_item),
    .pop_ready   (pop_ready),
    .res         (res)
  );

endmodule

>>> src/i2c_rbm_front.sv
// Front end: takes command items and classifies them for the item queue.
// Depends on i2c_rbm_pkg and i2c_rbm_cmd_if.
module i2c_rbm_front import i2c_rbm_pkg::*; (
  i2c_rbm_cmd_if.sink cmd,
  output logic        push_valid,
  output item_t       push_item,
  input  logic        push_ready
);

  assign cmd.ready  = push_ready;
  assign push_valid = cmd.valid;

  // only the fields the kind needs are carried, the rest are zeroed
  always_comb begin
    push_item = '0;
    push_item.kind = KIND_NOP;
    unique case (func_t'(cmd.func))
      FUNC_START: begin
        push_item.kind       = KIND_START;
        push_item.is_read    = cmd.is_read;
        push_item.dev_addr   = cmd.dev_addr;
        push_item.reg_addr   = cmd.reg_addr;
        push_item.byte_count = cmd.byte_count;
      end
      FUNC_DATA: begin
        push_item.kind       = KIND_DATA;
        push_item.write_data = cmd.write_data;
      end
      FUNC_TICK: begin
        push_item.kind   = KIND_TICK;
        push_item.sda_in = cmd.sda_in;
      end
      default: push_item.kind = KIND_NOP;
    endcase
  end

endmodule

>>> src/i2c_rbm_queue.sv
// Short item queue between the front end and the bus engine.
// Depends on i2c_rbm_pkg for the item type and depth.
module i2c_rbm_queue import i2c_rbm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  input  item_t push_item,
  output logic  push_ready,
  output logic  pop_valid,
  output item_t pop_item,
  input  logic  pop_ready
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  item_t            mem [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic [CntW-1:0]  count_next;
  logic             push;
  logic             pop;

  assign push_ready = (count != CntW'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CntW'(1);
    end else if (pop && !push) begin
      count_next = count - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

>>> src/i2c_rbm_engine.sv
// Bus engine: runs the I2C phase machine one queued item at a time and
// registers one result item per item taken. Depends on i2c_rbm_pkg, i2c_rbm_res_if.
module i2c_rbm_engine import i2c_rbm_pkg::*; #(
  parameter int TICKS_PER_DELAY = TICKS_PER_DELAY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       pop_valid,
  input  item_t      pop_item,
  output logic       pop_ready,
  i2c_rbm_res_if.source res
);

  localparam int DlyW = (TICKS_PER_DELAY > 1) ? $clog2(TICKS_PER_DELAY) : 1;
  localparam logic [DlyW-1:0] DLY_LAST = DlyW'(TICKS_PER_DELAY - 1);

  typedef enum logic [15:0] {
    PH_IDLE      = 16'h0001,
    PH_START_A   = 16'h0002,
    PH_START_B   = 16'h0004,
    PH_START_C   = 16'h0008,
    PH_TX_SETUP  = 16'h0010,
    PH_TX_HIGH   = 16'h0020,
    PH_ACK_LOW   = 16'h0040,
    PH_ACK_HIGH  = 16'h0080,
    PH_ACK_POLL  = 16'h0100,
    PH_WAIT_DATA = 16'h0200,
    PH_RX_LOW    = 16'h0400,
    PH_RX_HIGH   = 16'h0800,
    PH_RACK_LOW  = 16'h1000,
    PH_RACK_HIGH = 16'h2000,
    PH_STOP_A    = 16'h4000,
    PH_STOP_B    = 16'h8000
  } phase_t;

  typedef enum logic [3:0] {
    STG_ADDR_W = 4'b0001,
    STG_REG    = 4'b0010,
    STG_ADDR_R = 4'b0100,
    STG_DATA   = 4'b1000
  } stage_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       need_data;
    logic [7:0] read_data;
    logic       read_valid;
    logic       read_last;
    logic       done_res;
    logic       status;
    logic       cmd_rejected;
  } result_t;

  phase_t          phase, phase_next;
  stage_t          stage, stage_next;
  logic [DlyW-1:0] delay_count, delay_count_next;
  logic [3:0]      bit_index, bit_index_next;
  logic [7:0]      shift_byte, shift_byte_next;
  logic [7:0]      bytes_left, bytes_left_next;
  logic [6:0]      saved_device, saved_device_next;
  logic [7:0]      saved_register, saved_register_next;
  logic            read_mode, read_mode_next;
  logic [7:0]      held_data, held_data_next;
  logic            held_valid, held_valid_next;
  logic [7:0]      ack_polls, ack_polls_next;
  logic            failed, failed_next;
  logic            scl, scl_next;
  logic            sda, sda_next;
  logic            drive, drive_next;
  logic [7:0]      ack_limit;
  logic            res_valid;
  result_t         res_q, res_next;

  logic            pop;
  logic            step;
  logic            go_ack, go_tx, go_stop, go_rx, go_wait;
  logic [7:0]      tx_byte;
  logic [3:0]      bit_inc;
  logic [7:0]      bytes_dec;
  logic            rejected, rd_valid, rd_last, done;
  logic [7:0]      rd_data;

  assign pop_ready = !res_valid || res.ready;
  assign pop       = pop_valid && pop_ready;
  assign bit_inc   = bit_index + 4'd1;
  assign bytes_dec = bytes_left - 8'd1;

  always_comb begin
    phase_next          = phase;
    stage_next          = stage;
    delay_count_next    = delay_count;
    bit_index_next      = bit_index;
    shift_byte_next     = shift_byte;
    bytes_left_next     = bytes_left;
    saved_device_next   = saved_device;
    saved_register_next = saved_register;
    read_mode_next      = read_mode;
    held_data_next      = held_data;
    held_valid_next     = held_valid;
    ack_polls_next      = ack_polls;
    failed_next         = failed;
    scl_next            = scl;
    sda_next            = sda;
    drive_next          = drive;
    rejected = 1'b0;
    rd_valid = 1'b0;
    rd_last  = 1'b0;
    rd_data  = '0;
    done     = 1'b0;
    step     = 1'b0;
    go_ack   = 1'b0;
    go_tx    = 1'b0;
    go_stop  = 1'b0;
    go_rx    = 1'b0;
    go_wait  = 1'b0;
    tx_byte  = saved_register;

    unique case (pop_item.kind)
      KIND_START: begin
        if (phase != PH_IDLE) begin
          rejected = 1'b1;
        end else begin
          read_mode_next      = pop_item.is_read;
          saved_device_next   = pop_item.dev_addr;
          saved_register_next = pop_item.reg_addr;
          bytes_left_next     = pop_item.byte_count;
          held_valid_next     = 1'b0;
          failed_next         = 1'b0;
          stage_next          = STG_ADDR_W;
          delay_count_next    = '0;
          bit_index_next      = '0;
          ack_polls_next      = '0;
          scl_next            = 1'b1;
          sda_next            = 1'b1;
          drive_next          = 1'b1;
          phase_next          = PH_START_B;
        end
      end
      KIND_DATA: begin
        // one-byte slot; may be filled ahead while the address is going out
        if (phase != PH_IDLE && phase != PH_STOP_A && phase != PH_STOP_B &&
            !read_mode && !held_valid && bytes_left != '0) begin
          held_data_next  = pop_item.write_data;
          held_valid_next = 1'b1;
        end else begin
          rejected = 1'b1;
        end
      end
      KIND_TICK: begin
        case (phase)
          PH_IDLE: ;
          PH_WAIT_DATA: begin
            if (held_valid) begin
              held_valid_next = 1'b0;
              bytes_left_next = bytes_dec;
              go_tx           = 1'b1;
              tx_byte         = held_data;
            end
          end
          PH_ACK_POLL: begin
            if (!pop_pop_sda()) begin
              go_ack = 1'b1;
            end else if (ack_polls >= ack_limit) begin
              // register and read-address acknowledges are not enforced
              if (stage == STG_REG || stage == STG_ADDR_R) begin
                go_ack = 1'b1;
              end else begin
                failed_next     = 1'b1;
                held_valid_next = 1'b0;
                go_stop         = 1'b1;
              end
            end else begin
              ack_polls_next = ack_polls + 8'd1;
            end
          end
          default: begin
            if (delay_count != DLY_LAST) begin
              delay_count_next = delay_count + DlyW'(1);
            end else begin
              delay_count_next = '0;
              step             = 1'b1;
            end
          end
        endcase
      end
      default: ;
    endcase

    if (step) begin
      unique case (phase)
        PH_START_A: begin
          scl_next   = 1'b1;
          phase_next = PH_START_B;
        end
        PH_START_B: begin
          sda_next   = 1'b0;
          phase_next = PH_START_C;
        end
        PH_START_C: begin
          go_tx = 1'b1;
          if (stage == STG_REG) begin
            stage_next = STG_ADDR_R;
            tx_byte    = {saved_device, 1'b1};
          end else begin
            stage_next = STG_ADDR_W;
            tx_byte    = {saved_device, 1'b0};
          end
        end
        PH_TX_SETUP: begin
          scl_next   = 1'b1;
          phase_next = PH_TX_HIGH;
        end
        PH_TX_HIGH: begin
          scl_next        = 1'b0;
          shift_byte_next = {shift_byte[6:0], 1'b0};
          bit_index_next  = bit_inc;
          if (bit_inc >= 4'd8) begin
            drive_next = 1'b0;
            sda_next   = 1'b1;
            phase_next = PH_ACK_LOW;
          end else begin
            sda_next   = shift_byte[6];
            phase_next = PH_TX_SETUP;
          end
        end
        PH_ACK_LOW: begin
          scl_next   = 1'b1;
          phase_next = PH_ACK_HIGH;
        end
        PH_ACK_HIGH: begin
          ack_polls_next = '0;
          phase_next     = PH_ACK_POLL;
        end
        PH_RX_LOW: begin
          scl_next        = 1'b1;
          shift_byte_next = {shift_byte[6:0], pop_item.sda_in};
          bit_index_next  = bit_inc;
          phase_next      = PH_RX_HIGH;
        end
        PH_RX_HIGH: begin
          scl_next = 1'b0;
          if (bit_index >= 4'd8) begin
            drive_next = 1'b1;
            sda_next   = (bytes_left == 8'd1);
            phase_next = PH_RACK_LOW;
          end else begin
            phase_next = PH_RX_LOW;
          end
        end
        PH_RACK_LOW: begin
          scl_next   = 1'b1;
          phase_next = PH_RACK_HIGH;
        end
        PH_RACK_HIGH: begin
          scl_next        = 1'b0;
          rd_data         = shift_byte;
          rd_valid        = 1'b1;
          rd_last         = (bytes_left == 8'd1);
          bytes_left_next = bytes_dec;
          if (bytes_dec == '0) begin
            go_stop = 1'b1;
          end else begin
            go_rx = 1'b1;
          end
        end
        PH_STOP_A: begin
          scl_next   = 1'b1;
          phase_next = PH_STOP_B;
        end
        PH_STOP_B: begin
          sda_next   = 1'b1;
          drive_next = 1'b1;
          phase_next = PH_IDLE;
          done       = 1'b1;
        end
        default: phase_next = PH_IDLE;
      endcase
    end

    if (go_ack) begin
      scl_next = 1'b0;
      unique case (stage)
        STG_ADDR_W: begin
          stage_next = STG_REG;
          go_tx      = 1'b1;
          tx_byte    = saved_register;
        end
        STG_REG: begin
          if (read_mode) begin
            // repeated START
            sda_next   = 1'b1;
            drive_next = 1'b1;
            phase_next = PH_START_A;
          end else if (bytes_left == '0) begin
            go_stop = 1'b1;
          end else begin
            stage_next = STG_DATA;
            go_wait    = 1'b1;
          end
        end
        STG_ADDR_R: begin
          if (bytes_left == '0) begin
            go_stop = 1'b1;
          end else begin
            go_rx = 1'b1;
          end
        end
        default: begin
          if (bytes_left == '0) begin
            go_stop = 1'b1;
          end else begin
            go_wait = 1'b1;
          end
        end
      endcase
    end

    if (go_tx) begin
      shift_byte_next = tx_byte;
      bit_index_next  = '0;
      sda_next        = tx_byte[7];
      drive_next      = 1'b1;
      scl_next        = 1'b0;
      phase_next      = PH_TX_SETUP;
    end
    if (go_stop) begin
      scl_next   = 1'b0;
      sda_next   = 1'b0;
      drive_next = 1'b1;
      phase_next = PH_STOP_A;
    end
    if (go_rx) begin
      scl_next        = 1'b0;
      sda_next        = 1'b1;
      drive_next      = 1'b0;
      bit_index_next  = '0;
      shift_byte_next = '0;
      phase_next      = PH_RX_LOW;
    end
    if (go_wait) begin
      scl_next   = 1'b0;
      sda_next   = 1'b1;
      drive_next = 1'b0;
      phase_next = PH_WAIT_DATA;
    end

    res_next.scl_level    = scl_next;
    res_next.sda_level    = sda_next;
    res_next.sda_drive    = drive_next;
    res_next.busy_res     = (phase_next != PH_IDLE);
    res_next.need_data    = (phase_next == PH_WAIT_DATA) && !held_valid_next;
    res_next.read_data    = rd_data;
    res_next.read_valid   = rd_valid;
    res_next.read_last    = rd_last;
    res_next.done_res     = done;
    res_next.status       = done && failed_next;
    res_next.cmd_rejected = rejected;
  end

  function automatic logic pop_pop_sda();
    return pop_item.sda_in;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      stage       <= STG_ADDR_W;
      delay_count <= '0;
      bit_index   <= '0;
      bytes_left  <= '0;
      read_mode   <= 1'b0;
      held_valid  <= 1'b0;
      ack_polls   <= '0;
      failed      <= 1'b0;
      scl         <= 1'b1;
      sda         <= 1'b1;
      drive       <= 1'b1;
      res_valid   <= 1'b0;
    end else begin
      if (pop) begin
        phase       <= phase_next;
        stage       <= stage_next;
        delay_count <= delay_count_next;
        bit_index   <= bit_index_next;
        bytes_left  <= bytes_left_next;
        read_mode   <= read_mode_next;
        held_valid  <= held_valid_next;
        ack_polls   <= ack_polls_next;
        failed      <= failed_next;
        scl         <= scl_next;
        sda         <= sda_next;
        drive       <= drive_next;
        res_valid   <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      shift_byte     <= shift_byte_next;
      saved_device   <= saved_device_next;
      saved_register <= saved_register_next;
      held_data      <= held_data_next;
      res_q          <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_limit <= ACK_WAIT_RESET;
    end else if (cfg_wr_en) begin
      ack_limit <= cfg_wr_data;
    end
  end

  assign res.valid        = res_valid;
  assign res.scl_level    = res_q.scl_level;
  assign res.sda_level    = res_q.sda_level;
  assign res.sda_drive    = res_q.sda_drive;
  assign res.busy_res     = res_q.busy_res;
  assign res.need_data    = res_q.need_data;
  assign res.read_data    = res_q.read_data;
  assign res.read_valid   = res_q.read_valid;
  assign res.read_last    = res_q.read_last;
  assign res.done_res     = res_q.done_res;
  assign res.status       = res_q.status;
  assign res.cmd_rejected = res_q.cmd_rejected;

  a_held_write_only: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> !read_mode)
    else $error("held data byte present during a read burst");

  a_pop_fills_result: assert property (@(posedge clk) disable iff (rst)
    pop |=> res_valid)
    else $error("engine step did not produce a result item");

  a_ack_poll_released: assert property (@(posedge clk) disable iff (rst)
    phase == PH_ACK_POLL |-> (bit_index == 4'd8) && !drive)
    else $error("acknowledge poll without a full byte sent or with SDA driven");

  a_wait_in_write: assert property (@(posedge clk) disable iff (rst)
    phase == PH_WAIT_DATA |-> (stage == STG_DATA) && !read_mode && (bytes_left != '0))
    else $error("waiting for write data outside a write data stage");

endmodule
